>>> design/u8san_pkg.sv
// Package for the UTF-8 string sanitizer: shared constants, register codes,
// configuration and controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps

package u8san_pkg;

  // Lookahead window geometry
  localparam int LOOKAHEAD = 4;
  localparam int FILL_W    = $clog2(LOOKAHEAD + 1);
  localparam int WIDX_W    = $clog2(LOOKAHEAD);
  localparam int PASS_W    = $clog2(LOOKAHEAD);
  localparam int JUDGE_W   = $clog2(LOOKAHEAD + 1);

  // Field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;

  // APB port geometry
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Replacement for an unsafe byte ('?')
  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h3F;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_UTF8_MODE   = 2'd0,
    REG_ESC_PUA     = 2'd1,
    REG_MAX_LENGTH  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic             utf8_mode;
    logic             escape_private_use;
    logic [LEN_W-1:0] max_length;
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // item accepted this cycle
    logic emit;   // drive one byte from the window head
    logic flush;  // current emit run drains the whole window
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic start_emit;  // accepted item leads to an emit run
    logic end_now;     // accepted item ends the kept string
    logic emit_done;   // this emit step is the last of the run
    logic out_free;    // output register can take a byte
  } dp_status_t;

endpackage

>>> design/u8san_if.sv
// Stream interfaces for the sanitizer: input bytes and sanitized bytes.
// Depends on u8san_pkg.
`timescale 1ns / 1ps

interface u8san_in_if;
  logic                        valid;
  logic                        ready;
  logic [u8san_pkg::BYTE_W-1:0] data_byte;
  logic                        last_in;

  modport source (output valid, output data_byte, output last_in, input ready);
  modport sink   (input valid, input data_byte, input last_in, output ready);
endinterface

interface u8san_out_if;
  logic                        valid;
  logic                        ready;
  logic [u8san_pkg::BYTE_W-1:0] out_byte;
  logic                        out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> design/u8san_cfg.sv
// APB-style configuration registers of the sanitizer.
// Depends on u8san_pkg.
`timescale 1ns / 1ps

module u8san_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [u8san_pkg::APB_AW-1:0] paddr,
  input  logic [u8san_pkg::APB_DW-1:0] pwdata,
  output logic [u8san_pkg::APB_DW-1:0] prdata,
  output logic                         pready,
  output u8san_pkg::cfg_t              cfg_o
);
  import u8san_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_UTF8_MODE:  cfg_d.utf8_mode          = pwdata[0];
        REG_ESC_PUA:    cfg_d.escape_private_use = pwdata[0];
        REG_MAX_LENGTH: cfg_d.max_length         = pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.utf8_mode          <= 1'b1;
      cfg_q.escape_private_use <= 1'b1;
      cfg_q.max_length         <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_UTF8_MODE:  prdata[0]         = cfg_q.utf8_mode;
      REG_ESC_PUA:    prdata[0]         = cfg_q.escape_private_use;
      REG_MAX_LENGTH: prdata[LEN_W-1:0] = cfg_q.max_length;
      default: ;
    endcase
  end

endmodule

>>> design/u8san_ctrl.sv
// Controller of the sanitizer: accept/emit sequencing state machine.
// Depends on u8san_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps

module u8san_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  u8san_pkg::dp_status_t  status_i,
  output u8san_pkg::dp_cmd_t     cmd_o
);
  import u8san_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   flush_q;

  // Commands
  assign in_ready_o  = (state_q == S_IDLE);
  assign cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.emit  = (state_q == S_EMIT) && status_i.out_free;
  assign cmd_o.flush = flush_q;

  // State and run mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flush_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.load && status_i.start_emit) begin
            state_q <= S_EMIT;
            flush_q <= status_i.end_now;
          end
        end
        S_EMIT: begin
          if (cmd_o.emit && status_i.emit_done) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/u8san_dp.sv
// Datapath of the sanitizer: lookahead window, length counter, head judge
// and output register. Depends on u8san_pkg; commanded by u8san_ctrl.
`timescale 1ns / 1ps

module u8san_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  u8san_pkg::cfg_t              cfg_i,
  input  logic [u8san_pkg::BYTE_W-1:0] in_data_byte_i,
  input  logic                         in_last_i,
  input  u8san_pkg::dp_cmd_t           cmd_i,
  output u8san_pkg::dp_status_t        status_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [u8san_pkg::BYTE_W-1:0] out_byte_o,
  output logic                         out_last_o
);
  import u8san_pkg::*;

  // Code point ranges
  localparam logic [23:0] PUA3_LO   = 24'hEE8080;
  localparam logic [23:0] PUA3_HI   = 24'hEFA3BF;
  localparam logic [31:0] PUA15_LO  = 32'hF3B08080;
  localparam logic [31:0] PUA15_HI  = 32'hF3BFBFBD;
  localparam logic [31:0] PUA16_LO  = 32'hF4808080;
  localparam logic [31:0] PUA16_HI  = 32'hF48FBFBD;
  localparam logic [13:0] SEQ3A_LO  = 14'h3820;
  localparam logic [13:0] SEQ3A_HI  = 14'h3B5F;
  localparam logic [13:0] SEQ3B_LO  = 14'h3B80;
  localparam logic [13:0] SEQ3B_HI  = 14'h3BFF;
  localparam logic [13:0] SEQ4_LO   = 14'h3C10;
  localparam logic [13:0] SEQ4_HI   = 14'h3D0F;

  // Number of bytes passing unchanged from the window head, 0 = escape head
  function automatic logic [JUDGE_W-1:0] judge_head(
    input logic [BYTE_W-1:0] w0,
    input logic [BYTE_W-1:0] w1,
    input logic [BYTE_W-1:0] w2,
    input logic [BYTE_W-1:0] w3,
    input logic [FILL_W-1:0] fill,
    input logic              utf8,
    input logic              pua
  );
    logic [BYTE_W-1:0]  b0, b1, b2, b3;
    logic [23:0]        t;
    logic [31:0]        q;
    logic [13:0]        x;
    logic [JUDGE_W-1:0] n;
    b0 = w0;
    b1 = (fill > FILL_W'(1)) ? w1 : '0;
    b2 = (fill > FILL_W'(2)) ? w2 : '0;
    b3 = (fill > FILL_W'(3)) ? w3 : '0;
    t  = {b0, b1, b2};
    q  = {b0, b1, b2, b3};
    x  = {b0, b1[5:0]};
    priority if (!utf8) begin
      n = (b0 >= 8'h20 && b0 <= 8'h7E) ? JUDGE_W'(1) : JUDGE_W'(0);
    end else if (b0 <= 8'h7F) begin
      n = (b0 < 8'h20 || b0 == 8'h7F) ? JUDGE_W'(0) : JUDGE_W'(1);
    end else if (fill < FILL_W'(2) || b1[7:6] != 2'b10) begin
      n = JUDGE_W'(0);
    end else if (b0 >= 8'hC2 && b0 <= 8'hDF) begin
      // C1 controls escape their lead byte
      n = (b0 == 8'hC2 && b1 <= 8'h9F) ? JUDGE_W'(0) : JUDGE_W'(2);
    end else if (fill < FILL_W'(3) || b2[7:6] != 2'b10) begin
      n = JUDGE_W'(0);
    end else if (pua && t >= PUA3_LO && t <= PUA3_HI) begin
      n = JUDGE_W'(0);
    end else if ((x >= SEQ3A_LO && x <= SEQ3A_HI) || (x >= SEQ3B_LO && x <= SEQ3B_HI)) begin
      n = JUDGE_W'(3);
    end else if (fill < FILL_W'(4) || b3[7:6] != 2'b10) begin
      n = JUDGE_W'(0);
    end else if (pua && ((q >= PUA15_LO && q <= PUA15_HI) ||
                         (q >= PUA16_LO && q <= PUA16_HI))) begin
      n = JUDGE_W'(0);
    end else if (x >= SEQ4_LO && x <= SEQ4_HI) begin
      n = JUDGE_W'(4);
    end else begin
      n = JUDGE_W'(0);
    end
    return n;
  endfunction

  logic [BYTE_W-1:0] win_q [LOOKAHEAD];
  logic [BYTE_W-1:0] win_d [LOOKAHEAD];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic              trunc_q, trunc_d;
  logic [PASS_W-1:0] pass_q, pass_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  logic              append;
  logic [LEN_W:0]    cnt_inc;
  logic              end_now;
  logic [FILL_W-1:0] fill_load;
  logic [JUDGE_W-1:0] n_pass;
  logic [PASS_W-1:0] pass_nxt;
  logic              esc;

  // Accept-side decisions
  assign append    = !trunc_q && (cnt_q < cfg_i.max_length) &&
                     (fill_q < FILL_W'(LOOKAHEAD));
  assign cnt_inc   = {1'b0, cnt_q} + (LEN_W+1)'(1);
  assign end_now   = !trunc_q &&
                     (append ? (in_last_i || cnt_inc >= {1'b0, cfg_i.max_length}) : 1'b1);
  assign fill_load = append ? fill_q + FILL_W'(1) : fill_q;

  // Head judgement for the emit step
  assign n_pass   = judge_head(win_q[0], win_q[1], win_q[2], win_q[3], fill_q,
                               cfg_i.utf8_mode, cfg_i.escape_private_use);
  assign esc      = (pass_q == '0) && (n_pass == '0);
  assign pass_nxt = (pass_q != '0) ? pass_q - PASS_W'(1) :
                    (n_pass == '0) ? PASS_W'(0) : PASS_W'(n_pass - JUDGE_W'(1));

  // Status
  assign status_o.start_emit = !trunc_q && (fill_load != '0) &&
                               (end_now || !cfg_i.utf8_mode ||
                                fill_load == FILL_W'(LOOKAHEAD));
  assign status_o.end_now    = end_now;
  assign status_o.emit_done  = cmd_i.flush ? (fill_q == FILL_W'(1)) : (pass_nxt == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    trunc_d     = trunc_q;
    pass_d      = pass_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      if (trunc_q) begin
        // Dropping bytes until the end of an over-long string
        if (in_last_i) begin
          trunc_d = 1'b0;
          cnt_d   = '0;
        end
      end else begin
        if (append) begin
          win_d[fill_q[WIDX_W-1:0]] = in_data_byte_i;
          fill_d = fill_load;
          cnt_d  = cnt_inc[LEN_W-1:0];
        end
        if (end_now) begin
          if (in_last_i) begin
            cnt_d   = '0;
            trunc_d = 1'b0;
          end else begin
            trunc_d = 1'b1;
          end
        end
      end
    end
    if (cmd_i.emit) begin
      for (int i = 0; i < LOOKAHEAD - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      fill_d      = fill_q - FILL_W'(1);
      pass_d      = pass_nxt;
      out_valid_d = 1'b1;
      out_byte_d  = esc ? ESC_BYTE : win_q[0];
      out_last_d  = cmd_i.flush && (fill_q == FILL_W'(1));
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      cnt_q       <= '0;
      trunc_q     <= 1'b0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      trunc_q     <= trunc_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: window and output byte
  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // Checks
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> fill_q != '0)
    else $error("emit step with empty window");

  a_pass_within_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pass_q != '0) |-> ({1'b0, pass_q} <= fill_q))
    else $error("passing run longer than window");

  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (fill_q < FILL_W'(LOOKAHEAD) && pass_q == '0))
    else $error("item accepted with full window or open run");

endmodule

>>> design/utf8_sanitize_stream.sv
// Top level of the UTF-8 string sanitizer stream block.
// Depends on u8san_pkg, u8san_if, u8san_cfg, u8san_ctrl, u8san_dp.
`timescale 1ns / 1ps

// Filters string bytes one item at a time, keeps at most max_length bytes per
// string and emits each kept byte once, unchanged or replaced by '?'. A byte
// is accepted whenever the controller is idle; when it completes a decision
// (full four-byte window in UTF-8 mode, every byte in ASCII mode, or the end
// of the kept string) the emit sequencer then drives one byte per cycle, while
// the output register can take it, from the window head into that register:
// a run covers a passing sequence of 1 to 4 bytes, a single escaped head byte,
// or the whole window for the end-of-string flush. Accept and emit take turns,
// as they share the window head. Output stalls hold the sequencer but an
// idle block takes a new byte while the last result waits. No clearing pass.
module utf8_sanitize_stream (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  u8san_in_if.sink                     in_s,
  u8san_out_if.source                  out_s,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [u8san_pkg::APB_AW-1:0] paddr,
  input  logic [u8san_pkg::APB_DW-1:0] pwdata,
  output logic [u8san_pkg::APB_DW-1:0] prdata,
  output logic                         pready
);
  import u8san_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  u8san_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  u8san_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  u8san_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_data_byte_i (in_s.data_byte),
    .in_last_i      (in_s.last_in),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_s.ready),
    .out_valid_o    (out_s.valid),
    .out_byte_o     (out_s.out_byte),
    .out_last_o     (out_s.out_last)
  );

  assign in_s.ready = in_ready;

endmodule

>>> test/tb.sv
// Testbench for utf8_sanitize_stream: streams random and hand-picked string bytes,
// predicts the sanitized bytes in a local model, and checks every output item.
// Depends on u8san_pkg, u8san_if and the utf8_sanitize_stream RTL.
`timescale 1ns / 1ps

module tb;
  import u8san_pkg::*;

  typedef logic [7:0] octet_t;

  // one input item waiting to be driven
  typedef struct {
    octet_t data;
    logic   eol;
    bit     drain;  // hold this item until every expected byte has come out
  } raw_item_t;

  // one sanitized byte as the block should emit it
  typedef struct {
    octet_t data;
    logic   eol;
  } clean_item_t;

  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS  = 40;

  // directed strings: controls and ASCII extremes, C1 control, valid 2-byte,
  // private use (BMP and plane 16), valid 4-byte, invalid head + cut sequence
  localparam octet_t DIR_BYTES [25] = '{
    8'h00, 8'h7F, 8'h20, 8'h7E, 8'h1F,
    8'hC2, 8'h85,
    8'hC2, 8'hA0, 8'hDF, 8'hBF,
    8'hEE, 8'h80, 8'h80,
    8'hF4, 8'h8F, 8'hBF, 8'hBD,
    8'hF0, 8'h9F, 8'h98, 8'h80,
    8'hFF, 8'hE2, 8'h82
  };
  localparam logic [24:0] DIR_EOL = (25'd1 << 4) | (25'd1 << 6) | (25'd1 << 10) |
                                    (25'd1 << 13) | (25'd1 << 17) | (25'd1 << 21) |
                                    (25'd1 << 24);

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  wire  [APB_DW-1:0] prdata;
  wire               pready;

  u8san_in_if  in_if ();
  u8san_out_if out_if ();

  utf8_sanitize_stream u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_s    (in_if),
    .out_s   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // stimulus and expectation stores
  raw_item_t   raw_q[$];
  clean_item_t clean_q[$];
  bit          none_pending = 1'b1;
  int          errors = 0;

  // idling control, written by the stimulus at the falling edge
  bit calm = 1'b0;
  int hold_reqs = 0;

  // register shadow
  bit          sh_utf8 = 1'b1;
  bit          sh_pua  = 1'b1;
  int unsigned sh_max_len = 65535;

  // model state
  octet_t      win [4];
  int unsigned win_n = 0;
  int unsigned kept_cnt = 0;
  bit          trunc = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // number of head bytes that pass unchanged, 0 when the head gets escaped
  function automatic int unsigned head_pass_len(int unsigned avail);
    octet_t      b0, b1, b2, b3;
    logic [13:0] cp_hi;
    logic [23:0] tri_b;
    logic [31:0] quad_b;
    b0 = win[0];
    b1 = (avail > 1) ? win[1] : 8'h00;
    b2 = (avail > 2) ? win[2] : 8'h00;
    b3 = (avail > 3) ? win[3] : 8'h00;
    if (!sh_utf8) return (b0 >= 8'h20 && b0 <= 8'h7E) ? 1 : 0;
    if (b0 <= 8'h7F) return (b0 < 8'h20 || b0 == 8'h7F) ? 0 : 1;
    if (avail < 2 || b1[7:6] != 2'b10) return 0;
    // two-byte form; C1 controls are escaped
    if (b0 >= 8'hC2 && b0 <= 8'hDF) return (b0 == 8'hC2 && b1 <= 8'h9F) ? 0 : 2;
    if (avail < 3 || b2[7:6] != 2'b10) return 0;
    tri_b = {b0, b1, b2};
    if (sh_pua && tri_b >= 24'hEE8080 && tri_b <= 24'hEFA3BF) return 0;
    // lead plus first continuation: excludes overlongs and surrogates
    cp_hi = {b0, b1[5:0]};
    if ((cp_hi >= 14'h3820 && cp_hi <= 14'h3B5F) ||
        (cp_hi >= 14'h3B80 && cp_hi <= 14'h3BFF)) return 3;
    if (avail < 4 || b3[7:6] != 2'b10) return 0;
    quad_b = {b0, b1, b2, b3};
    if (sh_pua && ((quad_b >= 32'hF3B08080 && quad_b <= 32'hF3BFBFBD) ||
                   (quad_b >= 32'hF4808080 && quad_b <= 32'hF48FBFBD))) return 0;
    if (cp_hi >= 14'h3C10 && cp_hi <= 14'h3D0F) return 4;
    return 0;
  endfunction

  function automatic void win_drop(int unsigned n);
    for (int unsigned i = 0; i + n < win_n; i++) win[i] = win[i + n];
    win_n -= n;
  endfunction

  // advance the model by one accepted byte and queue what it emits
  function automatic void sanitize_byte(octet_t d, logic eol);
    bit          fin;
    int unsigned n;
    int unsigned emitted;
    emitted = 0;
    if (trunc) begin
      if (eol) begin
        trunc = 1'b0;
        kept_cnt = 0;
      end
      return;
    end
    if (kept_cnt < sh_max_len && win_n < 4) begin
      win[win_n] = d;
      win_n++;
      kept_cnt++;
      fin = eol || (kept_cnt >= sh_max_len);
    end else begin
      fin = 1'b1;
    end
    while (win_n > 0 && (fin || !sh_utf8 || win_n == 4)) begin
      n = head_pass_len(win_n);
      if (n == 0 || n > win_n) begin
        clean_q.push_back('{data: ESC_BYTE, eol: 1'b0});
        emitted++;
        win_drop(1);
      end else begin
        for (int unsigned i = 0; i < n; i++) clean_q.push_back('{data: win[i], eol: 1'b0});
        emitted += n;
        win_drop(n);
      end
      if (!fin) break;
    end
    if (fin) begin
      if (emitted > 0) clean_q[clean_q.size() - 1].eol = 1'b1;
      if (eol) begin
        kept_cnt = 0;
        trunc = 1'b0;
      end else begin
        trunc = 1'b1;
      end
    end
  endfunction

  // driver: offers the next pending item once the current one is taken
  always @(posedge clk_i) begin
    raw_item_t   nxt;
    int unsigned gap_left;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (raw_q.size() != 0 &&
                   (!raw_q[0].drain || (!in_if.valid && none_pending))) begin
        nxt = raw_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.data_byte <= nxt.data;
        in_if.last_in   <= nxt.eol;
        gap_left = calm ? 0 : idle_len();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    int hold_seen;
    int unsigned hold_left;
    int unsigned stall_left;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
      stall_left = 0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      stall_left = calm ? 0 : idle_len();
    end
  end

  // monitor: predicts on accepted input, checks accepted output
  always @(posedge clk_i) begin
    clean_item_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sanitize_byte(in_if.data_byte, in_if.last_in);
      if (out_if.valid && out_if.ready) begin
        if (clean_q.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected item, nothing expected, got byte %02h last %0b",
                     $time, out_if.out_byte, out_if.out_last);
          errors++;
        end else begin
          want = clean_q.pop_front();
          if (want.data !== out_if.out_byte || want.eol !== out_if.out_last) begin
            if (errors < MAX_REPORTS)
              $display("%0t: mismatch, expected byte %02h last %0b, got byte %02h last %0b",
                       $time, want.data, want.eol, out_if.out_byte, out_if.out_last);
            errors++;
          end
        end
      end
      none_pending <= (clean_q.size() == 0);
    end
  end

  task automatic apb_write(reg_idx_e idx, logic [APB_DW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_UTF8_MODE:  sh_utf8 = val[0];
      REG_ESC_PUA:    sh_pua = val[0];
      REG_MAX_LENGTH: sh_max_len = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // wait until every item went in and every expected byte came out
  task automatic wait_quiet();
    do @(negedge clk_i); while (raw_q.size() != 0 || in_if.valid || !none_pending);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic push_item(octet_t d, logic eol, bit drain);
    raw_q.push_back('{data: d, eol: eol, drain: drain});
  endtask

  // append one UTF-8-like sequence: mostly well-formed shapes, random content
  function automatic void add_seq(ref octet_t s[$]);
    int unsigned pick;
    int unsigned n;
    octet_t      lead;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      s.push_back(octet_t'($urandom_range(8'h20, 8'h7E)));
      return;
    end
    if (pick < 32) begin
      s.push_back(($urandom_range(0, 3) == 0) ? 8'h7F : octet_t'($urandom_range(0, 31)));
      return;
    end
    if (pick < 42) begin
      s.push_back(octet_t'($urandom_range(0, 255)));
      return;
    end
    if (pick < 57) begin
      n = 2;
      lead = ($urandom_range(0, 3) == 0) ? 8'hC2 : octet_t'($urandom_range(8'hC0, 8'hDF));
    end else if (pick < 78) begin
      n = 3;
      case ($urandom_range(0, 4))
        0: lead = 8'hE0;
        1: lead = 8'hED;
        2: lead = 8'hEE;
        3: lead = 8'hEF;
        default: lead = octet_t'($urandom_range(8'hE1, 8'hEC));
      endcase
    end else begin
      n = 4;
      case ($urandom_range(0, 4))
        0: lead = 8'hF0;
        1: lead = 8'hF3;
        2: lead = 8'hF4;
        3: lead = octet_t'($urandom_range(8'hF1, 8'hF2));
        default: lead = octet_t'($urandom_range(8'hF0, 8'hF7));
      endcase
    end
    s.push_back(lead);
    for (int unsigned i = 1; i < n; i++) s.push_back(octet_t'($urandom_range(8'h80, 8'hBF)));
    // now and then a sequence is cut short
    if ($urandom_range(0, 9) == 0) void'(s.pop_back());
  endfunction

  // queue whole strings until about n bytes are pending
  task automatic gen_strings(int n, bit ascii, int unsigned max_str);
    octet_t      s[$];
    int          made;
    int unsigned len;
    bit          drain;
    made = 0;
    while (made < n) begin
      s.delete();
      len = $urandom_range(1, max_str);
      while (s.size() < len) begin
        if (ascii)
          s.push_back(($urandom_range(0, 3) == 0) ? octet_t'($urandom_range(0, 255)) :
                                                    octet_t'($urandom_range(8'h20, 8'h7E)));
        else
          add_seq(s);
      end
      drain = ($urandom_range(0, 15) == 0);
      foreach (s[i]) push_item(s[i], i == s.size() - 1, drain && i == 0);
      made += s.size();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.last_in   = 1'b0;
    out_if.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed strings at reset settings
    for (int i = 0; i < 25; i++) push_item(DIR_BYTES[i], DIR_EOL[i], 1'b0);
    wait_quiet();

    // UTF-8 mode, private use escaped, no truncation
    gen_strings(130, 1'b0, 16);
    push_item(8'h41, 1'b1, 1'b1);
    wait_quiet();

    // private use passes; receiver holds off while the sender keeps offering
    apb_write(REG_ESC_PUA, 32'd0);
    calm = 1'b1;
    hold_reqs++;
    gen_strings(40, 1'b0, 16);
    wait_quiet();
    calm = 1'b0;
    gen_strings(60, 1'b0, 16);
    wait_quiet();

    // truncation at short limits
    apb_write(REG_ESC_PUA, 32'd1);
    apb_write(REG_MAX_LENGTH, 32'd5);
    gen_strings(50, 1'b0, 12);
    wait_quiet();
    apb_write(REG_MAX_LENGTH, 32'd1);
    gen_strings(40, 1'b0, 6);
    wait_quiet();
    apb_write(REG_MAX_LENGTH, 32'd0);
    calm = 1'b1;
    gen_strings(20, 1'b0, 6);
    wait_quiet();
    calm = 1'b0;

    // plain ASCII filter
    apb_write(REG_UTF8_MODE, 32'd0);
    apb_write(REG_MAX_LENGTH, 32'hFFFF);
    gen_strings(70, 1'b1, 16);
    wait_quiet();

    // limit lowered in the middle of a string
    for (int i = 0; i < 5; i++) push_item(octet_t'($urandom_range(0, 255)), 1'b0, 1'b0);
    wait_quiet();
    apb_write(REG_MAX_LENGTH, 32'd2);
    for (int i = 0; i < 4; i++) push_item(octet_t'($urandom_range(0, 255)), i == 3, 1'b0);
    wait_quiet();

    // back to UTF-8 with mid-range limits
    apb_write(REG_UTF8_MODE, 32'd1);
    apb_write(REG_MAX_LENGTH, 32'd3);
    gen_strings(30, 1'b0, 10);
    wait_quiet();
    apb_write(REG_MAX_LENGTH, $urandom_range(2, 20));
    gen_strings(30, 1'b0, 24);
    wait_quiet();

    errors += clean_q.size();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
